// ----- src/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, constants and helpers for the HTTP response header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // Buffer length limit and derived widths
  localparam int MAX_BYTES = 4096;
  localparam int POS_W     = $clog2(MAX_BYTES) + 1;  // holds MAX_BYTES itself
  localparam int OFS_W     = 12;                     // offset and length fields
  localparam int CODE_W    = 17;                     // signed status code
  localparam int MAG_W     = 16;                     // saturating magnitude
  localparam int PROD_W    = MAG_W + 4;              // magnitude * 10 + digit

  localparam logic [MAG_W-1:0] CODE_MAX = {MAG_W{1'b1}};

  // Version prefix "HTTP/1.1 "
  localparam logic [3:0] PREFIX_LEN = 4'd9;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Result kinds
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_STATUS = 2'd1,
    EV_HEADER = 2'd2
  } event_t;

  // One accepted input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result beat
  typedef struct packed {
    event_t                    event_res;
    logic                      finished;
    logic                      error;
    logic signed [CODE_W-1:0]  status_code;
    logic [OFS_W-1:0]          key_start;
    logic [OFS_W-1:0]          key_length;
    logic [OFS_W-1:0]          value_start;
    logic [OFS_W-1:0]          value_length;
  } result_t;

  // Expected byte of the version prefix at a given index
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h48;  // H
      4'd1:    ch = 8'h54;  // T
      4'd2:    ch = 8'h54;  // T
      4'd3:    ch = 8'h50;  // P
      4'd4:    ch = 8'h2F;  // /
      4'd5:    ch = 8'h31;  // 1
      4'd6:    ch = 8'h2E;  // .
      4'd7:    ch = 8'h31;  // 1
      4'd8:    ch = CH_SPACE;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) ||
           (ch == CH_FF) || (ch == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

// ----- src/hrhp_in_reg.sv -----
// ----------------------------------------------------------------------------
// hrhp_in_reg
// Input register: captures one byte beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module hrhp_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // data_byte
  input  logic            s_tlast,   // last_byte
  input  logic            take,      // core consumes the held beat this cycle
  output logic            vld,
  output hrhp_pkg::item_t item
);

  // Refill when empty or when the held beat leaves this cycle
  assign s_tready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      item.data_byte <= s_tdata;
      item.last_byte <= s_tlast;
    end
  end

endmodule

// ----- src/hrhp_core.sv -----
// ----------------------------------------------------------------------------
// hrhp_core
// Parser state and the single-byte step logic producing one result per byte.
// ----------------------------------------------------------------------------
module hrhp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,            // process the held byte
  input  logic              headers_only,
  input  hrhp_pkg::item_t   item,
  output hrhp_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_PREFIX      = 3'd1,
    PH_STATUS      = 3'd2,
    PH_KEY         = 3'd3,
    PH_AFTER_COLON = 3'd4,
    PH_VALUE_FIRST = 3'd5,
    PH_VALUE       = 3'd6,
    PH_DRAIN       = 3'd7
  } phase_t;

  phase_t                            phase, phase_next;
  logic [3:0]                        prefix_index, prefix_index_next;
  logic [hrhp_pkg::POS_W-1:0]        byte_position, byte_position_next;
  logic [hrhp_pkg::OFS_W-1:0]        key_begin, key_begin_next;
  logic [hrhp_pkg::OFS_W-1:0]        colon_position, colon_position_next;
  logic [hrhp_pkg::OFS_W-1:0]        value_begin, value_begin_next;
  logic [hrhp_pkg::MAG_W-1:0]        code_magnitude, code_magnitude_next;
  logic                              code_negative, code_negative_next;
  logic [1:0]                        number_stage, number_stage_next;

  always_comb begin
    logic [7:0]                   c;
    logic                         last;
    logic                         fail;
    logic                         done;
    logic                         dig;
    logic [hrhp_pkg::POS_W-1:0]   p;
    logic [hrhp_pkg::OFS_W-1:0]   p_ofs;
    logic [hrhp_pkg::PROD_W-1:0]  prod;
    logic [hrhp_pkg::CODE_W-1:0]  mag_ext;

    c       = item.data_byte;
    last    = item.last_byte;
    fail    = 1'b0;
    done    = 1'b0;
    dig     = 1'b0;
    p       = '0;
    p_ofs   = '0;
    prod    = '0;
    mag_ext = '0;

    phase_next          = phase;
    prefix_index_next   = prefix_index;
    byte_position_next  = byte_position;
    key_begin_next      = key_begin;
    colon_position_next = colon_position;
    value_begin_next    = value_begin;
    code_magnitude_next = code_magnitude;
    code_negative_next  = code_negative;
    number_stage_next   = number_stage;
    res                 = '0;

    if (phase == PH_DRAIN) begin
      // Swallow bytes up to the buffer's end mark
      if (last) begin
        phase_next         = PH_START;
        byte_position_next = '0;
      end
    end else begin
      if (phase == PH_START) begin
        phase_next          = headers_only ? PH_KEY : PH_PREFIX;
        prefix_index_next   = '0;
        byte_position_next  = '0;
        key_begin_next      = '0;
        colon_position_next = '0;
        value_begin_next    = '0;
        code_magnitude_next = '0;
        code_negative_next  = 1'b0;
        number_stage_next   = '0;
      end
      p     = byte_position_next;
      p_ofs = p[hrhp_pkg::OFS_W-1:0];

      if (p >= hrhp_pkg::POS_W'(hrhp_pkg::MAX_BYTES)) begin
        fail = 1'b1;
      end else begin
        case (phase_next)
          PH_PREFIX: begin
            if (prefix_index_next >= hrhp_pkg::PREFIX_LEN ||
                c != hrhp_pkg::prefix_char(prefix_index_next)) begin
              fail = 1'b1;
            end else begin
              prefix_index_next = prefix_index_next + 4'd1;
              if (prefix_index_next == hrhp_pkg::PREFIX_LEN) begin
                phase_next          = PH_STATUS;
                number_stage_next   = '0;
                code_magnitude_next = '0;
                code_negative_next  = 1'b0;
              end
              if (last) fail = 1'b1;
            end
          end
          PH_STATUS: begin
            if (c == hrhp_pkg::CH_LF) begin
              if (last || code_magnitude_next == '0) begin
                fail = 1'b1;
              end else begin
                mag_ext         = {1'b0, code_magnitude_next};
                res.event_res   = hrhp_pkg::EV_STATUS;
                res.status_code = code_negative_next ? -mag_ext : mag_ext;
                key_begin_next  = p_ofs + hrhp_pkg::OFS_W'(1);
                phase_next      = PH_KEY;
              end
            end else begin
              case (number_stage_next)
                2'd0: begin
                  if (hrhp_pkg::is_space(c)) begin
                    number_stage_next = 2'd0;
                  end else if (c == hrhp_pkg::CH_PLUS || c == hrhp_pkg::CH_MINUS) begin
                    code_negative_next = (c == hrhp_pkg::CH_MINUS);
                    number_stage_next  = 2'd1;
                  end else if (hrhp_pkg::is_digit(c)) begin
                    dig = 1'b1;
                  end else begin
                    number_stage_next = 2'd3;
                  end
                end
                2'd1, 2'd2: begin
                  if (hrhp_pkg::is_digit(c)) dig = 1'b1;
                  else number_stage_next = 2'd3;
                end
                default: number_stage_next = number_stage_next;
              endcase
              if (dig) begin
                // Shift in a decimal digit, saturating the magnitude
                prod = hrhp_pkg::PROD_W'(code_magnitude_next) * hrhp_pkg::PROD_W'(10) +
                       hrhp_pkg::PROD_W'(c - hrhp_pkg::CH_ZERO);
                code_magnitude_next = (prod > hrhp_pkg::PROD_W'(hrhp_pkg::CODE_MAX)) ?
                                      hrhp_pkg::CODE_MAX : prod[hrhp_pkg::MAG_W-1:0];
                number_stage_next   = 2'd2;
              end
              if (last) fail = 1'b1;
            end
          end
          PH_KEY: begin
            if (c == hrhp_pkg::CH_NUL) begin
              done = 1'b1;
            end else if (c == hrhp_pkg::CH_COLON) begin
              if ({1'b0, key_begin_next} == p || last) begin
                fail = 1'b1;
              end else begin
                colon_position_next = p_ofs;
                phase_next          = PH_AFTER_COLON;
              end
            end else if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF) begin
              if (({1'b0, key_begin_next} + hrhp_pkg::POS_W'(1)) < p) fail = 1'b1;
              else key_begin_next = p_ofs + hrhp_pkg::OFS_W'(1);
            end
          end
          PH_AFTER_COLON: begin
            if (c == hrhp_pkg::CH_SPACE) begin
              if (last) fail = 1'b1;
              else phase_next = PH_VALUE_FIRST;
            end else begin
              value_begin_next = p_ofs;
              phase_next       = PH_VALUE;
            end
          end
          PH_VALUE_FIRST: begin
            // First value byte is taken whatever it holds
            value_begin_next = p_ofs;
            phase_next       = PH_VALUE;
          end
          default: begin
            if (c == hrhp_pkg::CH_NUL) begin
              done = 1'b1;
            end else if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF) begin
              res.event_res    = hrhp_pkg::EV_HEADER;
              res.key_start    = key_begin_next;
              res.key_length   = colon_position_next - key_begin_next;
              res.value_start  = value_begin_next;
              res.value_length = p_ofs - value_begin_next;
              key_begin_next   = p_ofs + hrhp_pkg::OFS_W'(1);
              phase_next       = PH_KEY;
            end
          end
        endcase
      end

      byte_position_next = p + hrhp_pkg::POS_W'(1);
      if (fail) begin
        res          = '0;
        res.finished = 1'b1;
        res.error    = 1'b1;
      end else if (done || last) begin
        res.finished = 1'b1;
      end
      if (res.finished) begin
        if (last) begin
          phase_next         = PH_START;
          byte_position_next = '0;
        end else begin
          phase_next = PH_DRAIN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      prefix_index   <= '0;
      byte_position  <= '0;
      key_begin      <= '0;
      colon_position <= '0;
      value_begin    <= '0;
      code_magnitude <= '0;
      code_negative  <= 1'b0;
      number_stage   <= '0;
    end else if (en) begin
      phase          <= phase_next;
      prefix_index   <= prefix_index_next;
      byte_position  <= byte_position_next;
      key_begin      <= key_begin_next;
      colon_position <= colon_position_next;
      value_begin    <= value_begin_next;
      code_magnitude <= code_magnitude_next;
      code_negative  <= code_negative_next;
      number_stage   <= number_stage_next;
    end
  end

endmodule

// ----- src/http_response_header_parser.sv -----
// ----------------------------------------------------------------------------
// http_response_header_parser
// Byte-stream parser for an HTTP/1.1 response: status line and header lines.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake          | content
//   ---------+-----+--------------------+-----------------------------------
//   s_*      | in  | s_tvalid/s_tready  | one buffer byte, tlast = last byte
//   m_*      | out | m_tvalid/m_tready  | one result per byte, tlast = done
//   cfg_*    | in  | cfg_valid/cfg_ready| headers_only register
//
// Every byte beat yields exactly one result beat. Throughput is one byte per
// cycle while m_tready is held high; each byte passes the input register,
// then the per-byte step logic, then the result register.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the start of a buffer with headers_only cleared.
// A stalled result holds in the output register; the input register keeps
// taking beats as long as the result register is free or being emptied.
// ----------------------------------------------------------------------------
module http_response_header_parser (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [16:0] status_code, [28:17] key_start,
                                 // [40:29] key_length, [52:41] value_start,
                                 // [64:53] value_length, [71:65] zero
  output logic [2:0]  m_tuser,   // [1:0] event_res, [2] error
  output logic        m_tlast,   // finished
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // headers_only
);

  logic              headers_only;
  logic              in_vld;
  logic              advance;
  logic              step;
  hrhp_pkg::item_t   in_item;
  hrhp_pkg::result_t step_res;
  hrhp_pkg::result_t out_res;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      headers_only <= 1'b0;
    end else if (cfg_valid) begin
      headers_only <= cfg_data;
    end
  end

  // Result register is free, or its beat leaves this cycle
  assign advance = !m_tvalid || m_tready;
  assign step    = in_vld && advance;

  hrhp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .take     (advance),
    .vld      (in_vld),
    .item     (in_item)
  );

  hrhp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .en           (step),
    .headers_only (headers_only),
    .item         (in_item),
    .res          (step_res)
  );

  // Result register: load on every step, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_vld;
    end
    if (step) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {7'd0, out_res.value_length, out_res.value_start,
                    out_res.key_length, out_res.key_start, out_res.status_code};
  assign m_tuser = {out_res.error, out_res.event_res};
  assign m_tlast = out_res.finished;

endmodule
